@@ design/dclw_pkg.sv @@
package dclw_pkg;

	// width of the coordinate fields on the ports
	localparam int unsigned CW = 5;

	localparam logic [1:0] OP_DRAW       = 2'd0;
	localparam logic [1:0] OP_CLEAR      = 2'd1;
	localparam logic [1:0] OP_DRAW_CLEAR = 2'd2;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);

	localparam logic REG_TRACE = 1'b0;

	typedef struct packed {
		logic [CW-1:0] target_x;
		logic [CW-1:0] target_y;
	} in_item_t;

	typedef struct packed {
		logic [1:0]    pen_op;
		logic [CW-1:0] pos_x;
		logic [CW-1:0] pos_y;
		logic          last;
	} out_item_t;

	// one classified move, handed from the front to the walker
	typedef struct packed {
		logic                trace;
		logic                walk;
		logic                by_x;
		logic                maj_neg;
		logic [CW-1:0]       maj_start;
		logic [CW-1:0]       min_start;
		logic [CW-1:0]       dmaj;
		logic signed [CW:0]  dmin;
		logic [CW-1:0]       x1;
		logic [CW-1:0]       y1;
		logic [CW-1:0]       x2;
		logic [CW-1:0]       y2;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ design/dclw_front.sv @@
module dclw_front #(
	parameter int COORD_BITS = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  dclw_pkg::in_item_t in_data,
	input  logic              trace,
	input  dclw_pkg::q_stat_t q_stat,
	output logic              push,
	output dclw_pkg::job_t    job
);

	logic [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic [COORD_BITS-1:0] x2, y2;
	logic signed [COORD_BITS:0] dx, dy, adx, ady;
	logic by_x;

	assign x2 = in_data.target_x[COORD_BITS-1:0];
	assign y2 = in_data.target_y[COORD_BITS-1:0];

	always_comb begin
		dx   = $signed({1'b0, x2}) - $signed({1'b0, prev_x_q});
		dy   = $signed({1'b0, y2}) - $signed({1'b0, prev_y_q});
		adx  = dx[COORD_BITS] ? -dx : dx;
		ady  = dy[COORD_BITS] ? -dy : dy;
		by_x = adx >= ady;

		job.trace     = trace;
		job.walk      = (x2 != prev_x_q) || (y2 != prev_y_q);
		job.by_x      = by_x;
		job.maj_neg   = by_x ? dx[COORD_BITS] : dy[COORD_BITS];
		job.maj_start = dclw_pkg::CW'(by_x ? prev_x_q : prev_y_q);
		job.min_start = dclw_pkg::CW'(by_x ? prev_y_q : prev_x_q);
		job.dmaj      = dclw_pkg::CW'(by_x ? adx[COORD_BITS-1:0] : ady[COORD_BITS-1:0]);
		job.dmin      = (dclw_pkg::CW+1)'(by_x ? dy : dx);
		job.x1        = dclw_pkg::CW'(prev_x_q);
		job.y1        = dclw_pkg::CW'(prev_y_q);
		job.x2        = dclw_pkg::CW'(x2);
		job.y2        = dclw_pkg::CW'(y2);
	end

	assign in_stall = q_stat.full;
	assign push     = in_valid && !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else if (push) begin
			prev_x_q <= x2;
			prev_y_q <= y2;
		end
	end

endmodule

@@ design/dclw_queue.sv @@
module dclw_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dclw_pkg::job_t    push_job,
	input  logic              pop,
	output dclw_pkg::job_t    head_job,
	output dclw_pkg::q_stat_t q_stat
);

	dclw_pkg::job_t slot_q [dclw_pkg::QDEPTH];
	logic [dclw_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [dclw_pkg::QPTR_W:0]   cnt_q;

	assign q_stat.full  = cnt_q == (dclw_pkg::QPTR_W+1)'(dclw_pkg::QDEPTH);
	assign q_stat.empty = cnt_q == '0;
	assign head_job     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

@@ design/dclw_walker.sv @@
module dclw_walker (
	input  logic               clk,
	input  logic               arst_n,
	input  dclw_pkg::job_t     head_job,
	input  dclw_pkg::q_stat_t  q_stat,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output dclw_pkg::out_item_t out_data
);

	localparam int unsigned CW = dclw_pkg::CW;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CLEAR = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;
	localparam logic [1:0] ST_FINAL = 2'd3;

	logic [1:0]             state_q;
	dclw_pkg::job_t         job_q;
	logic [CW-1:0]          maj_q, min_q, cnt_q;
	logic signed [CW+1:0]   rem_q;
	logic                   out_valid_q;
	dclw_pkg::out_item_t    out_q;

	logic                   adv;
	dclw_pkg::out_item_t    emit;
	logic signed [CW+1:0]   rem_sum, rem_nx, dmaj_s;
	logic [CW-1:0]          min_nx;

	assign adv = !out_valid_q || !out_stall;
	assign pop = (state_q == ST_IDLE) && !q_stat.empty;

	always_comb begin
		emit.pen_op = dclw_pkg::OP_DRAW;
		emit.pos_x  = job_q.x2;
		emit.pos_y  = job_q.y2;
		emit.last   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				emit.pen_op = dclw_pkg::OP_CLEAR;
				emit.pos_x  = job_q.x1;
				emit.pos_y  = job_q.y1;
			end
			ST_WALK: begin
				emit.pen_op = job_q.trace ? dclw_pkg::OP_DRAW : dclw_pkg::OP_DRAW_CLEAR;
				emit.pos_x  = job_q.by_x ? maj_q : min_q;
				emit.pos_y  = job_q.by_x ? min_q : maj_q;
			end
			ST_FINAL: begin
				emit.last = 1'b1;
			end
			default: ;
		endcase
	end

	// exact floor(dmin*t/dmaj): remainder kept in [0, dmaj), one fixup per step
	always_comb begin
		dmaj_s  = $signed({2'b00, job_q.dmaj});
		rem_sum = rem_q + (CW+2)'(job_q.dmin);
		rem_nx  = rem_sum;
		min_nx  = min_q;
		if (!job_q.dmin[CW]) begin
			if (rem_sum >= dmaj_s) begin
				rem_nx = rem_sum - dmaj_s;
				min_nx = min_q + 1'b1;
			end
		end else if (rem_sum[CW+1]) begin
			rem_nx = rem_sum + dmaj_s;
			min_nx = min_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
			maj_q <= head_job.maj_start;
			min_q <= head_job.min_start;
			cnt_q <= head_job.dmaj;
			rem_q <= '0;
		end else if (state_q == ST_WALK && adv) begin
			maj_q <= job_q.maj_neg ? maj_q - 1'b1 : maj_q + 1'b1;
			min_q <= min_nx;
			rem_q <= rem_nx;
			cnt_q <= cnt_q - 1'b1;
		end
		if (adv)
			out_q <= emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (adv)
				out_valid_q <= state_q != ST_IDLE;
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (!head_job.trace)
							state_q <= ST_CLEAR;
						else if (head_job.walk)
							state_q <= ST_WALK;
						else
							state_q <= ST_FINAL;
					end
				end
				ST_CLEAR: begin
					if (adv)
						state_q <= job_q.walk ? ST_WALK : ST_FINAL;
				end
				ST_WALK: begin
					if (adv && cnt_q == '0)
						state_q <= ST_FINAL;
				end
				ST_FINAL: begin
					if (adv)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ design/dda_cursor_line_walker_top.sv @@
// Cursor line walker: each input item is a new cursor target; the block emits the pen
// commands that walk a DDA line from the previous target to this one (clear of the old
// point when trace is off, every line point, then a final draw at the target flagged
// last), at most 34 commands per move. The walker takes each classified move from the
// two-entry queue while idle, then registers one command per cycle unless stalled.
// The front classifies and queues one item per cycle unless the queue is full, so up
// to two moves can wait while the walker runs. trace_enable is APB register 0.
module dda_cursor_line_walker_top #(
	parameter int COORD_BITS = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  dclw_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output dclw_pkg::out_item_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic              trace_q;
	logic              push, pop;
	dclw_pkg::job_t    push_job, head_job;
	dclw_pkg::q_stat_t q_stat;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == dclw_pkg::REG_TRACE) ? {31'd0, trace_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			trace_q <= 1'b0;
		else if (psel && penable && pwrite && paddr[2] == dclw_pkg::REG_TRACE)
			trace_q <= pwdata[0];
	end

	dclw_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data (in_data),
		.trace   (trace_q),
		.q_stat  (q_stat),
		.push    (push),
		.job     (push_job)
	);

	dclw_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head_job(head_job),
		.q_stat  (q_stat)
	);

	dclw_walker u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_job (head_job),
		.q_stat   (q_stat),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

@@ design/dclw_checker.sv @@
module dclw_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input dclw_pkg::out_item_t out_data
);

	// a stalled item holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output item changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.pen_op == dclw_pkg::OP_DRAW
			|| out_data.pen_op == dclw_pkg::OP_CLEAR
			|| out_data.pen_op == dclw_pkg::OP_DRAW_CLEAR)
		else $error("undefined pen op");

	// every move ends on a plain draw at the target
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last |-> out_data.pen_op == dclw_pkg::OP_DRAW)
		else $error("last item is not a draw");

	// a clear only ever opens a move
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_data.pen_op == dclw_pkg::OP_CLEAR
			|=> !(out_valid && out_data.pen_op == dclw_pkg::OP_CLEAR))
		else $error("two clears in a row");

endmodule

bind dda_cursor_line_walker_top dclw_checker u_dclw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);
